// File: rtl/spmc_pkg.sv
// Shared types and constants of the gain-scheduled speed controller.
// No dependencies; compiled first.
package spmc_pkg;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 48;
  localparam int MUL_W       = 16;
  localparam int FULL_SCALE  = 25600;
  localparam int STOP_THRESH = 12;

  typedef enum logic [2:0] {
    MODE_STOP = 3'd0,
    MODE_FA   = 3'd1,
    MODE_FD   = 3'd2,
    MODE_RA   = 3'd3,
    MODE_RD   = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FA_GAINS = 3'd0,
    CFG_FD_GAINS = 3'd1,
    CFG_RA_GAINS = 3'd2,
    CFG_RD_GAINS = 3'd3,
    CFG_MARGIN   = 3'd4,
    CFG_FLOOR    = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MI,
    S_DV,
    S_ST,
    S_MP,
    S_MK,
    S_MD,
    S_FIN
  } state_e;

endpackage

// File: rtl/spmc_if.sv
// Handshake interfaces for input words, result words and config writes.
// Depends on spmc_pkg.
interface spmc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] target_speed;
  logic signed [15:0] measured_speed;
  logic        [15:0] time_step;
  modport source (output valid, target_speed, measured_speed, time_step, input ready);
  modport sink   (input valid, target_speed, measured_speed, time_step, output ready);
endinterface

interface spmc_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] throttle;
  logic [14:0] brake;
  logic        gear_valid;
  logic        gear_reverse;
  logic [2:0]  drive_mode;
  modport source (output valid, throttle, brake, gear_valid, gear_reverse, drive_mode,
                  input ready);
  modport sink   (input valid, throttle, brake, gear_valid, gear_reverse, drive_mode,
                  output ready);
endinterface

interface spmc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [spmc_pkg::CFG_IDX_W-1:0]   idx;
  logic [spmc_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

// File: rtl/spmc_mul.sv
// Shift-add multiplier: unsigned 16-bit multiplier times signed operand,
// one bit per cycle. Depends on spmc_pkg.
module spmc_mul #(
  parameter int OW = 34
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [spmc_pkg::MUL_W-1:0]        mult_i,
  input  logic signed [OW-1:0]              mcand_i,
  output logic                              done_o,
  output logic signed [OW+spmc_pkg::MUL_W-1:0] prod_o
);
  import spmc_pkg::*;

  localparam int PW = OW + MUL_W;

  logic                 busy_q;
  logic                 done_q;
  logic [3:0]           cnt_q;
  logic [MUL_W-1:0]     mb_q;
  logic signed [PW-1:0] x_q;
  logic signed [PW-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == 4'hF);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'hF) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mb_q  <= mult_i;
      x_q   <= PW'(mcand_i);
      acc_q <= '0;
    end else if (busy_q) begin
      if (mb_q[0]) begin
        acc_q <= acc_q + x_q;
      end
      x_q  <= x_q <<< 1;
      mb_q <= mb_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// File: rtl/speed_pid_mode_scheduler_top.sv
// Gain-scheduled speed PID with five drive modes; top level.
// Depends on spmc_pkg, spmc_if and spmc_mul.
//
//  channel | dir | payload                                              | accepted when
//  in_i    | in  | target_speed, measured_speed, time_step             | valid && ready
//  out_o   | out | throttle, brake, gear_valid, gear_reverse, drive_mode | valid && ready
//  cfg_i   | in  | idx, data                                            | valid && ready
//
// A moving step runs four shift-add multiplies on one shared multiplier plus a
// restoring divide by the time step.
// A step ending in stop skips the gain multiplies.
// A zero time step is accepted and gives no word.
// Reset is asynchronous and clears mode, integrator state and config registers.
// A held output word stalls the last cycle of the next step only.
module speed_pid_mode_scheduler_top #(
  parameter int GAIN_WIDTH     = 16,
  parameter int INTEGRAL_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  spmc_in_if.sink     in_i,
  spmc_out_if.source  out_o,
  spmc_cfg_if.sink    cfg_i
);
  import spmc_pkg::*;

  localparam int OW = (INTEGRAL_WIDTH > 34) ? INTEGRAL_WIDTH : 34;
  localparam int PW = OW + MUL_W;
  localparam int UW = OW + 10;
  localparam int TW = UW + 1;
  localparam int SW = ((INTEGRAL_WIDTH > 26) ? INTEGRAL_WIDTH : 26) + 2;
  localparam logic signed [SW-1:0] IMAX = SW'((longint'(1) <<< (INTEGRAL_WIDTH-1)) - 1);
  localparam logic signed [SW-1:0] IMIN = -IMAX - SW'(1);
  localparam logic signed [15:0]   THR_P = 16'(STOP_THRESH);
  localparam logic signed [15:0]   THR_N = -THR_P;
  localparam logic signed [TW-1:0] FS_T = TW'(FULL_SCALE);
  localparam logic [14:0]          FS15 = 15'(FULL_SCALE);

  // config
  logic [47:0] g_fa_q, g_fd_q, g_ra_q, g_rd_q;
  logic [14:0] margin_q, floor_q;

  // state
  state_e                         state_q, state_d;
  mode_e                          mode_q;
  logic signed [16:0]             last_err_q;
  logic signed [INTEGRAL_WIDTH-1:0] integ_q, saved_q;

  // work
  logic signed [15:0] tgt_q, meas_q;
  logic [15:0]        dt_q;
  logic signed [16:0] e_q;
  logic               dneg_q;
  logic [15:0]        rem_q;
  logic [32:0]        dq_q;
  logic [5:0]         dcnt_q;
  logic signed [UW-1:0] u_q;
  logic               gv_q, gr_q;

  logic               mstart_q;
  logic [MUL_W-1:0]   ma_q;
  logic signed [OW-1:0] mb_q;
  logic               mdone;
  logic signed [PW-1:0] prod;

  // output
  logic        ovalid_q;
  logic [14:0] othr_q, obrk_q;
  logic        ogv_q, ogr_q;
  logic [2:0]  omode_q;

  spmc_mul #(.OW(OW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mstart_q),
    .mult_i  (ma_q),
    .mcand_i (mb_q),
    .done_o  (mdone),
    .prod_o  (prod)
  );

  // mode after the stop stage
  mode_e st_mode;
  always_comb begin
    st_mode = mode_q;
    if (mode_q == MODE_STOP) begin
      if (tgt_q > 0 && meas_q >= THR_N) st_mode = MODE_FA;
      if (tgt_q < 0 && meas_q <= THR_P) st_mode = MODE_RA;
    end
  end

  // gain select
  logic [47:0]      gsel;
  logic [MUL_W-1:0] kp, ki, kd;
  always_comb begin
    unique case (st_mode)
      MODE_FA: gsel = g_fa_q;
      MODE_FD: gsel = g_fd_q;
      MODE_RA: gsel = g_ra_q;
      MODE_RD: gsel = g_rd_q;
      default: gsel = '0;
    endcase
    kp = MUL_W'(gsel[GAIN_WIDTH-1:0]);
    ki = MUL_W'(gsel[16+GAIN_WIDTH-1:16]);
    kd = MUL_W'(gsel[32+GAIN_WIDTH-1:32]);
  end

  // input side
  logic               in_acc;
  logic signed [15:0] tgt_in;
  logic signed [16:0] e_in;
  logic               small_tgt;
  assign in_acc    = in_i.valid && in_i.ready;
  assign small_tgt = (in_i.target_speed >= THR_N) && (in_i.target_speed <= THR_P);
  assign tgt_in    = small_tgt ? '0 : in_i.target_speed;
  assign e_in      = 17'(tgt_in) - 17'(in_i.measured_speed);

  // integral update
  logic signed [SW-1:0] isum;
  logic signed [INTEGRAL_WIDTH-1:0] isat;
  always_comb begin
    isum = SW'(integ_q) + SW'(prod >>> 8);
    if (isum > IMAX)      isat = IMAX[INTEGRAL_WIDTH-1:0];
    else if (isum < IMIN) isat = IMIN[INTEGRAL_WIDTH-1:0];
    else                  isat = isum[INTEGRAL_WIDTH-1:0];
  end

  logic signed [17:0] diff;
  assign diff = 18'(e_q) - 18'(last_err_q);

  // divider step
  logic [16:0] dsh;
  logic [17:0] dtrial;
  assign dsh    = {rem_q, dq_q[32]};
  assign dtrial = {1'b0, dsh} - {2'b0, dt_q};

  logic signed [33:0] dval;
  assign dval = dneg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});

  // finish
  logic signed [17:0]  em, mg;
  logic [14:0]         fv;
  logic signed [TW-1:0] fv_t, u_t, thr, brk;
  mode_e               nm;
  logic                sw, oor;
  logic [14:0]         thr_c, brk_c;
  logic signed [INTEGRAL_WIDTH-1:0] int_n, sav_n;
  always_comb begin
    em   = 18'(e_q);
    mg   = $signed({3'b0, margin_q});
    fv   = (floor_q > FS15) ? FS15 : floor_q;
    fv_t = $signed({{(TW-15){1'b0}}, fv});
    u_t  = TW'(u_q);
    nm   = mode_q;
    sw   = 1'b0;
    thr  = '0;
    brk  = FS_T;
    unique case (mode_q)
      MODE_FA: begin
        thr = u_t;
        brk = fv_t;
        if (tgt_q > 0 && em < -mg && u_q <= 0) begin
          sw = 1'b1;
          nm = MODE_FD;
        end
        if (tgt_q <= 0) nm = MODE_STOP;
      end
      MODE_FD: begin
        brk = fv_t - u_t;
        if (tgt_q > 0 && em > mg && u_q > 0) begin
          sw = 1'b1;
          nm = MODE_FA;
        end
        if (tgt_q <= 0) nm = MODE_STOP;
      end
      MODE_RA: begin
        thr = -u_t;
        brk = fv_t;
        if (tgt_q < 0 && em > mg) begin
          sw = 1'b1;
          nm = MODE_RD;
        end
        if (tgt_q >= 0) nm = MODE_STOP;
      end
      MODE_RD: begin
        brk = u_t + fv_t;
        if (tgt_q < 0 && em < -mg) begin
          sw = 1'b1;
          nm = MODE_RA;
        end
        if (tgt_q >= 0) nm = MODE_STOP;
      end
      default: ;
    endcase
    oor   = (thr < 0) || (thr > FS_T) || (brk < fv_t) || (brk > FS_T);
    int_n = sw ? '0 : integ_q;
    sav_n = sw ? '0 : saved_q;
    if (oor) int_n = sav_n;
    if (thr < 0)          thr_c = '0;
    else if (thr > FS_T)  thr_c = FS15;
    else                  thr_c = thr[14:0];
    if (brk < fv_t)       brk_c = fv;
    else if (brk > FS_T)  brk_c = FS15;
    else                  brk_c = brk[14:0];
  end

  // next state
  logic fin_go;
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc && in_i.time_step != '0) state_d = S_MI;
      S_MI:   if (mdone) state_d = S_DV;
      S_DV:   if (dcnt_q == 6'd32) state_d = S_ST;
      S_ST:   state_d = (st_mode == MODE_STOP) ? S_FIN : S_MP;
      S_MP:   if (mdone) state_d = S_MK;
      S_MK:   if (mdone) state_d = S_MD;
      S_MD:   if (mdone) state_d = S_FIN;
      S_FIN:  if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_i.ready  = (state_q == S_IDLE);
    cfg_i.ready = 1'b1;
    fin_go      = (state_q == S_FIN) && (!ovalid_q || out_o.ready);
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.throttle     = othr_q;
  assign out_o.brake        = obrk_q;
  assign out_o.gear_valid   = ogv_q;
  assign out_o.gear_reverse = ogr_q;
  assign out_o.drive_mode   = omode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mode_q     <= MODE_STOP;
      last_err_q <= '0;
      integ_q    <= '0;
      saved_q    <= '0;
      g_fa_q     <= '0;
      g_fd_q     <= '0;
      g_ra_q     <= '0;
      g_rd_q     <= '0;
      margin_q   <= '0;
      floor_q    <= '0;
      ovalid_q   <= 1'b0;
      mstart_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      mstart_q <= ((state_q == S_IDLE) && in_acc && (in_i.time_step != '0)) ||
                  ((state_q == S_ST) && (st_mode != MODE_STOP)) ||
                  (((state_q == S_MP) || (state_q == S_MK)) && mdone);
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.idx)
          CFG_FA_GAINS: g_fa_q   <= cfg_i.data;
          CFG_FD_GAINS: g_fd_q   <= cfg_i.data;
          CFG_RA_GAINS: g_ra_q   <= cfg_i.data;
          CFG_RD_GAINS: g_rd_q   <= cfg_i.data;
          CFG_MARGIN:   margin_q <= cfg_i.data[14:0];
          CFG_FLOOR:    floor_q  <= cfg_i.data[14:0];
          default: ;
        endcase
      end
      if (fin_go) ovalid_q <= 1'b1;
      else if (ovalid_q && out_o.ready) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && in_i.time_step != '0) begin
            if (small_tgt) mode_q <= MODE_STOP;
          end
        end
        S_MI: begin
          if (mdone) integ_q <= isat;
        end
        S_ST: begin
          if (mode_q == MODE_STOP) begin
            integ_q <= '0;
            saved_q <= '0;
          end
          mode_q <= st_mode;
        end
        S_FIN: begin
          if (fin_go) begin
            mode_q     <= nm;
            last_err_q <= e_q;
            integ_q    <= int_n;
            saved_q    <= int_n;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          tgt_q  <= tgt_in;
          meas_q <= in_i.measured_speed;
          dt_q   <= in_i.time_step;
          e_q    <= e_in;
          ma_q   <= in_i.time_step;
          mb_q   <= OW'(e_in);
          gv_q   <= 1'b0;
          gr_q   <= 1'b0;
        end
      end
      S_MI: begin
        dneg_q <= diff[17];
        rem_q  <= '0;
        dcnt_q <= '0;
        dq_q   <= {(diff[17] ? 17'(-diff) : 17'(diff)), 16'b0};
      end
      S_DV: begin
        dcnt_q <= dcnt_q + 6'd1;
        if (!dtrial[17]) begin
          rem_q <= dtrial[15:0];
          dq_q  <= {dq_q[31:0], 1'b1};
        end else begin
          rem_q <= dsh[15:0];
          dq_q  <= {dq_q[31:0], 1'b0};
        end
      end
      S_ST: begin
        ma_q <= kp;
        mb_q <= OW'(e_q);
        u_q  <= '0;
        if (mode_q == MODE_STOP && st_mode == MODE_FA) gv_q <= 1'b1;
        if (mode_q == MODE_STOP && st_mode == MODE_RA) begin
          gv_q <= 1'b1;
          gr_q <= 1'b1;
        end
      end
      S_MP: begin
        if (mdone) begin
          u_q  <= UW'(prod >>> 8);
          ma_q <= ki;
          mb_q <= OW'(integ_q);
        end
      end
      S_MK: begin
        if (mdone) begin
          u_q  <= u_q + UW'(prod >>> 16);
          ma_q <= kd;
          mb_q <= OW'(dval);
        end
      end
      S_MD: begin
        if (mdone) u_q <= u_q + UW'(prod >>> 8);
      end
      S_FIN: begin
        if (fin_go) begin
          othr_q  <= thr_c;
          obrk_q  <= brk_c;
          ogv_q   <= gv_q;
          ogr_q   <= gr_q;
          omode_q <= nm;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/spmc_chk.sv
// Port-level checks for the speed controller top; bound to it below.
// Depends on spmc_pkg and speed_pid_mode_scheduler_top.
module spmc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [14:0] throttle,
  input logic [14:0] brake,
  input logic        gear_valid,
  input logic        gear_reverse,
  input logic [2:0]  drive_mode
);
  import spmc_pkg::*;

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (throttle <= 15'(FULL_SCALE)) && (brake <= 15'(FULL_SCALE)))
    else $error("command above full scale");

  a_gear_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && gear_valid |-> (drive_mode != MODE_STOP) && (drive_mode <= MODE_RD))
    else $error("gear word outside a moving mode");

  a_gear_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (gear_reverse == (gear_valid && (drive_mode >= MODE_RA))))
    else $error("gear direction mismatch");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(throttle) && $stable(brake)
      && $stable(drive_mode))
    else $error("stalled word changed");

endmodule

bind speed_pid_mode_scheduler_top spmc_chk u_spmc_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .throttle     (out_o.throttle),
  .brake        (out_o.brake),
  .gear_valid   (out_o.gear_valid),
  .gear_reverse (out_o.gear_reverse),
  .drive_mode   (out_o.drive_mode)
);

// File: verif/spmc_scoreboard.sv
// Speed controller predictor and result scoreboard for the testbench.
// Depends on spmc_pkg; holds its own copy of registers and controller state.
class spmc_scoreboard;
  typedef struct packed {
    logic [14:0] throttle;
    logic [14:0] brake;
    logic        gear_valid;
    logic        gear_reverse;
    logic [2:0]  drive_mode;
  } ctrl_word_t;

  logic [47:0] gains [4];
  longint margin, brake_min;
  spmc_pkg::mode_e mode;
  longint last_err, integ, integ_saved;
  ctrl_word_t pending[$];
  int errors, checked;

  function new();
    for (int i = 0; i < 4; i++) gains[i] = '0;
    margin = 0; brake_min = 0;
    mode = spmc_pkg::MODE_STOP;
    last_err = 0; integ = 0; integ_saved = 0;
    errors = 0; checked = 0;
  endfunction

  function void write_reg(spmc_pkg::cfg_idx_e idx, logic [47:0] val);
    case (idx)
      spmc_pkg::CFG_FA_GAINS, spmc_pkg::CFG_FD_GAINS,
      spmc_pkg::CFG_RA_GAINS, spmc_pkg::CFG_RD_GAINS: gains[int'(idx)] = val;
      spmc_pkg::CFG_MARGIN: margin = longint'(val[14:0]);
      spmc_pkg::CFG_FLOOR:  brake_min = longint'(val[14:0]);
      default: ;
    endcase
  endfunction

  function longint fdiv(longint x, int k);
    return x >>> k;
  endfunction

  function longint law(logic [47:0] g, longint e, longint d);
    longint kp, ki, kd, hi, lo;
    kp = longint'(g[15:0]); ki = longint'(g[31:16]); kd = longint'(g[47:32]);
    hi = fdiv(integ, 16);
    lo = integ - hi * 65536;
    return fdiv(kp * e, 8) + ki * hi + ((ki * lo) >>> 16) + fdiv(kd * d, 8);
  endfunction

  function longint clip(longint lo, longint v, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function void note_input(logic signed [15:0] tgt_in, logic signed [15:0] meas_in,
                           logic [15:0] dt_in);
    longint tgt, meas, dt, fl, imax, e, diff, d, u, thr, brk, mag;
    bit gv, gr;
    ctrl_word_t w;
    tgt = tgt_in; meas = meas_in; dt = dt_in;
    thr = 0; brk = 0; gv = 0; gr = 0;
    if (dt == 0) return;
    fl = brake_min > spmc_pkg::FULL_SCALE ? spmc_pkg::FULL_SCALE : brake_min;
    imax = (longint'(1) <<< 31) - 1;
    if (tgt >= -spmc_pkg::STOP_THRESH && tgt <= spmc_pkg::STOP_THRESH) begin
      tgt = 0;
      mode = spmc_pkg::MODE_STOP;
    end
    e = tgt - meas;
    integ = clip(-imax - 1, integ + fdiv(e * dt, 8), imax);
    diff = e - last_err;
    mag = (diff < 0 ? -diff : diff) <<< 16;
    d = mag / dt;
    if (diff < 0) d = -d;
    if (mode == spmc_pkg::MODE_STOP) begin
      integ = 0; integ_saved = 0;
      brk = spmc_pkg::FULL_SCALE;
      if (tgt > 0 && meas >= -spmc_pkg::STOP_THRESH) begin
        mode = spmc_pkg::MODE_FA; gv = 1; gr = 0;
      end
      if (tgt < 0 && meas <= spmc_pkg::STOP_THRESH) begin
        mode = spmc_pkg::MODE_RA; gv = 1; gr = 1;
      end
    end
    if (mode == spmc_pkg::MODE_FA) begin
      u = law(gains[0], e, d);
      thr = u; brk = fl;
      if (tgt > 0 && e < -margin && u <= 0) begin
        integ = 0; integ_saved = 0; mode = spmc_pkg::MODE_FD;
      end
      if (tgt <= 0) mode = spmc_pkg::MODE_STOP;
    end else if (mode == spmc_pkg::MODE_FD) begin
      u = law(gains[1], e, d);
      thr = 0; brk = fl - u;
      if (tgt > 0 && e > margin && u > 0) begin
        integ = 0; integ_saved = 0; mode = spmc_pkg::MODE_FA;
      end
      if (tgt <= 0) mode = spmc_pkg::MODE_STOP;
    end
    if (mode == spmc_pkg::MODE_RA) begin
      u = law(gains[2], e, d);
      thr = -u; brk = fl;
      if (tgt < 0 && e > margin) begin
        integ = 0; integ_saved = 0; mode = spmc_pkg::MODE_RD;
      end
      if (tgt >= 0) mode = spmc_pkg::MODE_STOP;
    end else if (mode == spmc_pkg::MODE_RD) begin
      u = law(gains[3], e, d);
      thr = 0; brk = u + fl;
      if (tgt < 0 && e < -margin) begin
        integ = 0; integ_saved = 0; mode = spmc_pkg::MODE_RA;
      end
      if (tgt >= 0) mode = spmc_pkg::MODE_STOP;
    end
    last_err = e;
    if (thr < 0 || thr > spmc_pkg::FULL_SCALE || brk < fl || brk > spmc_pkg::FULL_SCALE)
      integ = integ_saved;
    integ_saved = integ;
    w.throttle = 15'(clip(0, thr, spmc_pkg::FULL_SCALE));
    w.brake = 15'(clip(fl, brk, spmc_pkg::FULL_SCALE));
    w.gear_valid = gv;
    w.gear_reverse = gr;
    w.drive_mode = mode;
    pending.push_back(w);
  endfunction

  function void check_result(ctrl_word_t got);
    ctrl_word_t exp_w;
    checked++;
    if (pending.size() == 0) begin
      errors++;
      $display("%0t: unexpected word %p", $realtime, got);
      return;
    end
    exp_w = pending.pop_front();
    if (exp_w.throttle != got.throttle) begin
      errors++;
      $display("%0t: throttle exp %0d got %0d", $realtime, exp_w.throttle, got.throttle);
    end
    if (exp_w.brake != got.brake) begin
      errors++;
      $display("%0t: brake exp %0d got %0d", $realtime, exp_w.brake, got.brake);
    end
    if (exp_w.gear_valid != got.gear_valid) begin
      errors++;
      $display("%0t: gear_valid exp %0d got %0d", $realtime, exp_w.gear_valid,
               got.gear_valid);
    end
    if (exp_w.gear_reverse != got.gear_reverse) begin
      errors++;
      $display("%0t: gear_reverse exp %0d got %0d", $realtime, exp_w.gear_reverse,
               got.gear_reverse);
    end
    if (exp_w.drive_mode != got.drive_mode) begin
      errors++;
      $display("%0t: drive_mode exp %0d got %0d", $realtime, exp_w.drive_mode,
               got.drive_mode);
    end
  endfunction
endclass

// File: verif/testbench.sv
// Testbench for speed_pid_mode_scheduler_top: directed and random speed steps
// across gain settings, checked word by word. Depends on spmc_pkg, spmc_if, RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import spmc_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk_i, rst_ni;
  spmc_in_if  in_ch();
  spmc_out_if out_ch();
  spmc_cfg_if cfg_ch();

  speed_pid_mode_scheduler_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_i(cfg_ch.sink)
  );

  spmc_scoreboard sb;
  int src_idle_pct, snk_idle_pct, idle_cycles, sent;

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    in_ch.valid = 0; in_ch.target_speed = 0; in_ch.measured_speed = 0;
    in_ch.time_step = 0;
    cfg_ch.valid = 0; cfg_ch.idx = CFG_FA_GAINS; cfg_ch.data = 0;
    out_ch.ready = 0;
  end

  always @(negedge clk_i) out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.throttle, out_ch.brake, out_ch.gear_valid,
                       out_ch.gear_reverse, out_ch.drive_mode});
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("** speed_pid_mode_scheduler_top: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [47:0] val);
    cfg_ch.valid <= 1; cfg_ch.idx <= idx; cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic send_step(logic signed [15:0] tgt, logic signed [15:0] meas,
                           logic [15:0] dt);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1; in_ch.target_speed <= tgt; in_ch.measured_speed <= meas;
    in_ch.time_step <= dt;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(tgt, meas, dt);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  function automatic logic [47:0] rand_gains(int scale);
    logic [15:0] g [3];
    for (int i = 0; i < 3; i++)
      case (scale)
        0: g[i] = 16'($urandom_range(0, 1023));
        1: g[i] = 16'($urandom);
        default: g[i] = 16'hFFFF;
      endcase
    return {g[2], g[1], g[0]};
  endfunction

  task automatic setup(int scale, logic [14:0] marg, logic [14:0] flr);
    write_reg(CFG_FA_GAINS, rand_gains(scale));
    write_reg(CFG_FD_GAINS, rand_gains(scale));
    write_reg(CFG_RA_GAINS, rand_gains(scale));
    write_reg(CFG_RD_GAINS, rand_gains(scale));
    write_reg(CFG_MARGIN, 48'(marg));
    write_reg(CFG_FLOOR, 48'(flr));
    cfg_ch.valid <= 0;
  endtask

  // drive cycle: pick a target, chase it with nearby measured speeds
  task automatic random_run(int n);
    logic signed [15:0] tgt, meas;
    logic [15:0] dt;
    int k;
    k = 0;
    tgt = 0; meas = 0;
    while (k < n) begin
      case ($urandom_range(9))
        0: begin
          tgt = 16'($urandom); meas = 16'($urandom);
        end
        1: begin
          tgt = 16'($signed($urandom_range(0, 26)) - 13);
        end
        2, 3: begin
          tgt = 16'($signed($urandom_range(0, 3000)) - 1500);
          meas = 16'($signed($urandom_range(0, 40)) - 20);
        end
        default: meas = meas + 16'($signed($urandom_range(0, 200)) - 100);
      endcase
      case ($urandom_range(19))
        0: dt = 0;
        1: dt = 16'hFFFF;
        2: dt = 16'($urandom_range(1, 4));
        default: dt = 16'($urandom_range(1000, 8000));
      endcase
      send_step(tgt, meas, dt);
      if (dt != 0) k++;
    end
  endtask

  initial begin
    sb = new();
    idle_cycles = 0; sent = 0;
    src_idle_pct = 11; snk_idle_pct = 65;
    rst_ni = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    setup(0, 15'd64, 15'd0);
    send_step(16'sd0, 16'sd0, 16'd100);
    send_step(16'sd12, 16'sd0, 16'd100);
    send_step(16'sd13, -16'sd12, 16'd100);
    send_step(16'sd400, 16'sd0, 16'd0);
    send_step(16'sd400, 16'sd100, 16'd1);
    send_step(16'sd400, 16'sd900, 16'hFFFF);
    send_step(16'sd400, 16'sd900, 16'd300);
    send_step(16'sd400, 16'sd100, 16'd300);
    send_step(-16'sd400, 16'sd100, 16'd300);
    send_step(-16'sd13, 16'sd12, 16'd300);
    send_step(-16'sd400, -16'sd900, 16'd300);
    send_step(-16'sd400, 16'sd100, 16'd300);
    send_step(-16'sd12, 16'sd0, 16'd300);
    send_step(-16'sd400, 16'sd13, 16'd300);
    send_step(16'sh7FFF, 16'sh8000, 16'hFFFF);
    send_step(16'sh7FFF, 16'sh8000, 16'hFFFF);
    send_step(16'sh8000, 16'sh7FFF, 16'd1);
    send_step(16'sh8000, 16'sd0, 16'd1);
    send_step(16'sh8000, 16'sh7FFF, 16'hFFFF);
    drain();

    setup(2, 15'h7FFF, 15'h7FFF);
    send_step(16'sd500, 16'sd0, 16'd2000);
    send_step(16'sd500, 16'sd200, 16'd2000);
    send_step(-16'sd500, 16'sd0, 16'd2000);
    send_step(-16'sd500, -16'sd200, 16'd2000);
    drain();

    setup(0, 15'd0, 15'd25600);
    random_run(500);
    drain();

    src_idle_pct = 65; snk_idle_pct = 11;
    setup(1, 15'($urandom_range(0, 2000)), 15'($urandom_range(0, 3000)));
    random_run(300);
    drain();
    setup(0, 15'd200, 15'd1000);
    random_run(300);
    drain();

    src_idle_pct = 0; snk_idle_pct = 0;
    setup(0, 15'($urandom_range(0, 500)), 15'd0);
    random_run(450);
    drain();

    $display("Sent %0d speed steps over six gain settings; checked %0d control words.",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("** speed_pid_mode_scheduler_top: PASSED **");
    else
      $display("** speed_pid_mode_scheduler_top: FAILED **");
    $finish;
  end
endmodule

// File: files.f
rtl/spmc_pkg.sv
rtl/spmc_if.sv
rtl/spmc_mul.sv
rtl/speed_pid_mode_scheduler_top.sv
rtl/spmc_chk.sv
verif/spmc_scoreboard.sv
verif/testbench.sv
